@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ src/qpi_pkg.sv @@
// ----------------------------------------------------------------------------
// Queue with priority insert: shared package
// Operation codes, status codes, widths and the cell control bundle.
// ----------------------------------------------------------------------------
package qpi_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int OCC_W         = 5;

    typedef enum logic [1:0] {
        MODE_ENQ = 2'd0,
        MODE_INS = 2'd1,
        MODE_DEQ = 2'd2,
        MODE_NOP = 2'd3
    } mode_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Operation broadcast to every cell, already qualified by full/empty.
    typedef struct packed {
        logic enq;
        logic ins;
        logic deq;
    } cell_ctrl_t;

endpackage

@@ src/qpi_cell.sv @@
// ----------------------------------------------------------------------------
// Queue cell
// Holds one queue entry and decides whether to hold, load the new value,
// take its left neighbor (shift toward tail) or its right neighbor (shift
// toward head).
// ----------------------------------------------------------------------------
module qpi_cell #(
    parameter int DEPTH = qpi_pkg::DEPTH_DEFAULT,
    parameter int INDEX = 0
) (
    input  logic                                 clk,
    input  qpi_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [qpi_pkg::DATA_W-1:0]    value,
    input  logic [$clog2(DEPTH+1)-1:0]           count,
    input  logic signed [qpi_pkg::DATA_W-1:0]    left_data,
    input  logic signed [qpi_pkg::DATA_W-1:0]    right_data,
    input  logic                                 found_in,
    output logic signed [qpi_pkg::DATA_W-1:0]    data,
    output logic                                 found_out
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [qpi_pkg::DATA_W-1:0] data_reg;
    logic signed [qpi_pkg::DATA_W-1:0] data_next;
    logic occupied;
    logic at_tail;
    logic smaller;

    assign occupied  = CW'(INDEX) < count;
    assign at_tail   = count == CW'(INDEX);
    assign smaller   = occupied && (data_reg < value);
    // Set once some cell at or before this one holds a smaller entry.
    assign found_out = found_in || smaller;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.enq && at_tail)
        begin
            data_next = value;
        end
        else if (ctrl.ins)
        begin
            if (found_in && (occupied || at_tail))
            begin
                data_next = left_data;
            end
            else if (!found_in && (smaller || at_tail))
            begin
                data_next = value;
            end
        end
        else if (ctrl.deq)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ src/queue_with_priority_insert_core.sv @@
// ----------------------------------------------------------------------------
// Queue with priority insert
// Bounded queue of signed values with tail enqueue, priority insert and
// head dequeue, built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle: busy never rises, so
// start may stay high continuously. Each transaction produces exactly one
// result, presented on status, head_value and occupancy for one cycle with
// done high, in the cycle right after the one in which it was accepted. The
// receiver cannot stall, so it must capture a result whenever done is high.
// The queue lives in DEPTH cells; every cell compares its own entry with the
// incoming value in parallel, and a flag rippling from head to tail marks the
// insertion point, so the length of that ripple through the cell row is what
// sets the cycle time. Entries shift one cell toward the tail to open a gap
// on insert, and one cell toward the head on dequeue, all in the same cycle.
// A priority insert places the value ahead of the first held entry that is
// strictly smaller, so equal values keep arrival order. Enqueues and inserts
// on a full queue report status full and dequeues on an empty queue report
// status empty; in both cases the queue is left as it was. Mode three is a
// no-op. Occupancy shows the low five bits of the count after the operation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module queue_with_priority_insert_core #(
    parameter int DEPTH = qpi_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          mode,
    input  logic signed [qpi_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [qpi_pkg::DATA_W-1:0]   head_value,
    output logic [qpi_pkg::OCC_W-1:0]           occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic signed [qpi_pkg::DATA_W-1:0] head_value_reg;
    logic signed [qpi_pkg::DATA_W-1:0] head_value_next;
    logic [qpi_pkg::OCC_W-1:0] occupancy_reg;
    logic [31:0]   count_wide;

    logic          full;
    logic          empty;
    qpi_pkg::cell_ctrl_t ctrl;

    // Cell chain: stored entries and the insertion-point flag between cells.
    logic signed [qpi_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH:0] found;

    // The queue accepts a transaction every cycle.
    assign busy  = 1'b0;
    assign full  = count_reg == CW'(DEPTH);
    assign empty = count_reg == '0;

    // Decode the operation and qualify it against the current fill level.
    always_comb
    begin
        ctrl            = '0;
        count_next      = count_reg;
        status_next     = qpi_pkg::ST_OK;
        head_value_next = '0;
        unique case (qpi_pkg::mode_t'(mode)) inside
            qpi_pkg::MODE_ENQ,
            qpi_pkg::MODE_INS:
            begin
                if (full)
                begin
                    status_next = qpi_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.enq   = (qpi_pkg::mode_t'(mode) == qpi_pkg::MODE_ENQ);
                    ctrl.ins   = (qpi_pkg::mode_t'(mode) == qpi_pkg::MODE_INS);
                    count_next = count_reg + CW'(1);
                end
            end
            qpi_pkg::MODE_DEQ:
            begin
                if (empty)
                begin
                    status_next = qpi_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.deq        = 1'b1;
                    head_value_next = cell_data[0];
                    count_next      = count_reg - CW'(1);
                end
            end
            default:
            begin
                // No operation: everything holds.
            end
        endcase
        if (!start)
        begin
            ctrl       = '0;
            count_next = count_reg;
        end
    end

    assign count_wide = 32'(count_next);
    assign found[0]   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [qpi_pkg::DATA_W-1:0] left_d;
            logic signed [qpi_pkg::DATA_W-1:0] right_d;

            if (gi == 0)
            begin : g_head
                assign left_d = value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            qpi_cell #(
                .DEPTH (DEPTH),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .value      (value),
                .count      (count_reg),
                .left_data  (left_d),
                .right_data (right_d),
                .found_in   (found[gi]),
                .data       (cell_data[gi]),
                .found_out  (found[gi+1])
            );
        end
    endgenerate

    // Count and result strobe carry reset; result payload does not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            status_reg     <= status_next;
            head_value_reg <= head_value_next;
            occupancy_reg  <= count_wide[qpi_pkg::OCC_W-1:0];
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign head_value = head_value_reg;
    assign occupancy  = occupancy_reg;

    // The count never runs past the number of cells.
    `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    // Every accepted transaction yields a result in the next cycle.
    `ASSERT_NEXT(a_result_follows, clk, rst_n, start && !busy, done)
    // A successful dequeue shrinks the queue by exactly one entry.
    `ASSERT_NEXT(a_deq_shrinks, clk, rst_n,
        start && (mode == qpi_pkg::MODE_DEQ) && (count_reg != '0),
        (count_reg == $past(count_reg) - CW'(1)) && (status == qpi_pkg::ST_OK))
    // A full report leaves the queue at its capacity.
    `ASSERT_SAME(a_full_at_capacity, clk, rst_n,
        done && (status == qpi_pkg::ST_FULL), count_reg == CW'(DEPTH))

endmodule
